// ===== design/psieve_pkg.sv =====
package psieve_pkg;

  localparam int MAX_LIMIT_DEF = 4095;
  localparam int VALUE_W       = 12;
  localparam int FIRST_PRIME   = 2;

  localparam logic CMD_SIEVE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [VALUE_W-1:0] value;
  } psieve_req_t;

  typedef struct packed {
    logic ok;
    logic is_prime;
  } psieve_rsp_t;

endpackage

// ===== design/prime_sieve_engine_core.sv =====
// Sieve of Eratosthenes over a one-bit primality map held in a single-port-write,
// registered-read memory of MAX_LIMIT+1 entries. Issue a beat with start while busy
// is low. A query beat (cmd = query) reads the map as it is taken and registers its
// result in S_QRESP: ok says the number lies inside the covered range, is_prime is
// its map bit gated by ok. A sieve beat with limit N that extends the covered range
// rewrites entries 0..N in S_FILL, then for each i = 2, 3, ... with i*i <= N reads
// map bit i (S_OUT_RD, S_OUT_WAIT) and, if i is still marked prime, strikes its
// multiples from i*i to N in S_STRIKE. A sieve beat that cannot extend the map
// (limit zero, above capacity, or already covered) answers ok = 0 the cycle after
// it is taken. Each result is flagged by done for exactly one cycle and held on rsp
// until the next; the receiver cannot stall it, so it must take every beat as it
// comes. The map memory needs no clearing after reset: only covered entries reach rsp.
module prime_sieve_engine_core
  import psieve_pkg::*;
#(
  parameter int MAX_LIMIT = MAX_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  psieve_req_t req,
  output logic        done,
  output psieve_rsp_t rsp
);

  localparam int AW   = $clog2(MAX_LIMIT + 1);
  localparam int CMPW = ((AW > VALUE_W) ? AW : VALUE_W) + 1;
  localparam int SQW  = 2 * AW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_OUT_RD,
    S_OUT_WAIT,
    S_STRIKE,
    S_QRESP
  } state_t;

  state_t          state;
  logic [AW:0]     covered_size;
  logic [AW-1:0]   lim;
  logic [AW-1:0]   i_cnt;
  logic [AW:0]     j_cnt;
  logic            q_ok;

  logic            map [MAX_LIMIT+1];
  logic            rd_data;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic            mem_wdata;
  logic [AW-1:0]   mem_raddr;

  logic [CMPW-1:0] val_ext;
  logic [CMPW-1:0] cov_ext;
  logic            sieve_go;
  logic            query_hit;
  logic [SQW-1:0]  i_sq;
  logic            outer_done;
  logic [AW:0]     j_sum;
  logic            strike_last;

  assign val_ext   = CMPW'(req.value);
  assign cov_ext   = CMPW'(covered_size);
  assign sieve_go  = (val_ext != '0) && (val_ext <= CMPW'(MAX_LIMIT)) && (val_ext >= cov_ext);
  assign query_hit = (val_ext < cov_ext);

  assign i_sq        = SQW'(i_cnt) * SQW'(i_cnt);
  assign outer_done  = (i_sq > SQW'(lim));
  assign j_sum       = j_cnt + {1'b0, i_cnt};
  assign strike_last = (j_sum > {1'b0, lim});

  assign busy = (state != S_IDLE);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = j_cnt[AW-1:0];
    mem_wdata = 1'b0;
    mem_raddr = i_cnt;
    case (state)
      S_IDLE:   mem_raddr = val_ext[AW-1:0];
      S_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = (j_cnt >= (AW+1)'(FIRST_PRIME));
      end
      S_STRIKE: mem_we = 1'b1;
      default:  mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map[mem_waddr] <= mem_wdata;
    end
    rd_data <= map[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      covered_size <= '0;
      done         <= 1'b0;
      rsp          <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            lim   <= val_ext[AW-1:0];
            j_cnt <= '0;
            i_cnt <= AW'(FIRST_PRIME);
            q_ok  <= query_hit;
            if (req.cmd == CMD_QUERY) begin
              state <= S_QRESP;
            end else if (sieve_go) begin
              state <= S_FILL;
            end else begin
              done <= 1'b1;
              rsp  <= '0;
            end
          end
        end
        S_FILL: begin
          if (j_cnt == {1'b0, lim}) begin
            state <= S_OUT_RD;
          end
          j_cnt <= j_cnt + 1'b1;
        end
        S_OUT_RD: begin
          if (outer_done) begin
            state        <= S_IDLE;
            covered_size <= {1'b0, lim} + 1'b1;
            done         <= 1'b1;
            rsp.ok       <= 1'b1;
            rsp.is_prime <= 1'b0;
          end else begin
            j_cnt <= i_sq[AW:0];
            state <= S_OUT_WAIT;
          end
        end
        S_OUT_WAIT: begin
          if (rd_data) begin
            state <= S_STRIKE;
          end else begin
            i_cnt <= i_cnt + 1'b1;
            state <= S_OUT_RD;
          end
        end
        S_STRIKE: begin
          if (strike_last) begin
            i_cnt <= i_cnt + 1'b1;
            state <= S_OUT_RD;
          end else begin
            j_cnt <= j_sum;
          end
        end
        S_QRESP: begin
          state        <= S_IDLE;
          done         <= 1'b1;
          rsp.ok       <= q_ok;
          rsp.is_prime <= q_ok & rd_data;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted beat neither started work nor answered");

  a_cov_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (covered_size >= $past(covered_size)))
    else $error("covered size shrank");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> ({1'b0, mem_waddr} <= {1'b0, lim}))
    else $error("map write beyond sieve limit");

  a_prime_needs_ok: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.is_prime) |-> rsp.ok)
    else $error("prime flag without coverage");

  a_cov_bound: assert property (@(posedge clk) disable iff (rst)
    1'b1 |-> ((AW+1)'(MAX_LIMIT + 1) >= covered_size))
    else $error("covered size above capacity");
`endif

endmodule

// ===== tb/prime_sieve_engine_checker.sv =====
module prime_sieve_engine_checker
  import psieve_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  psieve_req_t req,
  input  logic        done,
  input  psieve_rsp_t rsp,
  output int          fails,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  logic        prime_table [0:MAX_LIMIT_DEF];
  logic [12:0] covered_cnt;
  psieve_rsp_t rsp_due [$];

  initial begin
    for (int k = 0; k <= MAX_LIMIT_DEF; k++) begin
      prime_table[k] = 1'b0;
    end
    covered_cnt = '0;
    fails       = 0;
    outstanding = 0;
  end

  // Applies one request to the shadow map and returns the response it earns.
  function automatic psieve_rsp_t sieve_response(psieve_req_t r);
    psieve_rsp_t res;
    int          lim;
    int          i;
    int          j;
    res = '0;
    lim = int'(r.value);
    if (r.cmd == CMD_SIEVE) begin
      if (lim != 0 && lim <= MAX_LIMIT_DEF && lim + 1 > int'(covered_cnt)) begin
        for (i = int'(covered_cnt); i <= lim; i++) begin
          prime_table[i] = 1'b1;
        end
        prime_table[0] = 1'b0;
        prime_table[1] = 1'b0;
        for (i = FIRST_PRIME; i * i <= lim; i++) begin
          if (prime_table[i]) begin
            for (j = i * i; j <= lim; j += i) begin
              prime_table[j] = 1'b0;
            end
          end
        end
        covered_cnt = 13'(lim + 1);
        res.ok = 1'b1;
      end
    end else begin
      if (lim < int'(covered_cnt) && lim <= MAX_LIMIT_DEF) begin
        res.ok       = 1'b1;
        res.is_prime = prime_table[lim];
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    psieve_rsp_t want;
    if (rst) begin
      rsp_due.delete();
      covered_cnt = '0;
      outstanding = 0;
    end else begin
      if (done) begin
        if (rsp_due.size() == 0) begin
          $display("%0t: result with none due: expected none, actual ok=%b is_prime=%b",
                   $time, rsp.ok, rsp.is_prime);
          fails = fails + 1;
        end else begin
          want = rsp_due.pop_front();
          if (rsp.ok !== want.ok) begin
            $display("%0t: ok mismatch: expected %b, actual %b", $time, want.ok, rsp.ok);
            fails = fails + 1;
          end
          if (rsp.is_prime !== want.is_prime) begin
            $display("%0t: is_prime mismatch: expected %b, actual %b",
                     $time, want.is_prime, rsp.is_prime);
            fails = fails + 1;
          end
        end
      end
      if (start && !busy) begin
        rsp_due.push_back(sieve_response(req));
      end
      outstanding = rsp_due.size();
    end
  end

endmodule

// ===== tb/prime_sieve_engine_core_tb.sv =====
module prime_sieve_engine_core_tb;
  import psieve_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 200000;
  localparam int RANDOM_BEATS = 66;
  localparam int RANDOM_REACH_CAP = 2000;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  psieve_req_t req;
  logic        done;
  psieve_rsp_t rsp;
  int          fails;
  int          outstanding;
  int          quiet_cycles;
  int          reach;

  prime_sieve_engine_core uut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .rsp  (rsp)
  );

  prime_sieve_engine_checker chk (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req        (req),
    .done       (done),
    .rsp        (rsp),
    .fails      (fails),
    .outstanding(outstanding)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("prime_sieve_engine_core_tb failed");
      $finish;
    end
  end

  // Holds start high until the beat is taken; start stays high for the caller.
  task automatic send_beat(logic cmd, logic [VALUE_W-1:0] value);
    start     <= 1'b1;
    req.cmd   <= cmd;
    req.value <= value;
    if (cmd == CMD_SIEVE && int'(value) > reach) begin
      reach = int'(value);
    end
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_for(int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic send_random_beat;
    int pick;
    int lim;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      if ($urandom_range(0, 1) == 1) begin
        send_beat(CMD_QUERY, VALUE_W'($urandom_range(0, reach)));
      end else begin
        send_beat(CMD_QUERY, VALUE_W'($urandom));
      end
    end else if (pick < 82 && reach < RANDOM_REACH_CAP) begin
      lim = reach + $urandom_range(1, 48);
      send_beat(CMD_SIEVE, VALUE_W'(lim));
    end else begin
      send_beat(CMD_SIEVE, VALUE_W'($urandom_range(0, reach)));
    end
  endtask

  initial begin
    int sent;
    int burst;
    quiet_cycles = 0;
    reach        = 0;
    rst          = 1'b1;
    start        = 1'b0;
    req          = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty map, degenerate limits, first tiny extensions
    send_beat(CMD_QUERY, 12'd0);
    send_beat(CMD_QUERY, 12'd4095);
    send_beat(CMD_SIEVE, 12'd0);
    send_beat(CMD_SIEVE, 12'd1);
    send_beat(CMD_QUERY, 12'd0);
    send_beat(CMD_QUERY, 12'd1);
    send_beat(CMD_QUERY, 12'd2);
    send_beat(CMD_SIEVE, 12'd1);
    send_beat(CMD_SIEVE, 12'd2);
    send_beat(CMD_QUERY, 12'd2);
    idle_for(3);
    send_beat(CMD_SIEVE, 12'd30);
    send_beat(CMD_QUERY, 12'd29);
    send_beat(CMD_QUERY, 12'd30);
    send_beat(CMD_QUERY, 12'd31);
    send_beat(CMD_SIEVE, 12'd30);
    send_beat(CMD_SIEVE, 12'd20);
    send_beat(CMD_SIEVE, 12'd121);
    send_beat(CMD_QUERY, 12'd121);
    send_beat(CMD_QUERY, 12'd113);
    send_beat(CMD_QUERY, 12'd120);
    drain();

    sent = 0;
    while (sent < RANDOM_BEATS) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        send_random_beat();
        sent++;
      end
      if ($urandom_range(0, 3) != 0) begin
        idle_for($urandom_range(1, 8));
      end
    end
    drain();

    // full capacity
    send_beat(CMD_SIEVE, 12'd4095);
    send_beat(CMD_QUERY, 12'd4095);
    send_beat(CMD_QUERY, 12'd4093);
    send_beat(CMD_QUERY, 12'd4094);
    send_beat(CMD_SIEVE, 12'd4095);
    repeat (8) begin
      send_beat(CMD_QUERY, VALUE_W'($urandom));
    end
    drain();

    repeat (20) @(posedge clk);
    if (fails == 0) begin
      $display("prime_sieve_engine_core_tb passed");
    end else begin
      $display("prime_sieve_engine_core_tb failed");
    end
    $finish;
  end

endmodule
